// File: rtl/vlbp_pkg.sv
// shared types and constants for the variable-length bit packer
// no dependencies

package vlbp_pkg;

   localparam int MAX_CODE_BITS = 32;
   localparam int PEND_W        = 7;
   localparam int CNT3_W        = 3;
   localparam int ACC_W         = MAX_CODE_BITS + PEND_W;
   localparam int LEN_W         = 6;
   localparam int TOT_W         = $clog2(ACC_W + 1);
   localparam int MAX_BYTES     = ACC_W / 8;
   localparam int NB_W          = $clog2(MAX_BYTES + 1);

   typedef enum logic [0:0] {
      FUNC_PUSH  = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

   // packed word handed to the byte emitter, first bit at the top
   typedef struct packed {
      logic             load;
      logic [ACC_W-1:0] word;
      logic [NB_W-1:0]  nbytes;
   } burst_type;

endpackage

// File: rtl/vlbp_pack.sv
// input register, pending-bit state and packing logic
// depends on vlbp_pkg

module vlbp_pack
   import vlbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [0:0]       req_func,
   input  logic [31:0]      req_code_bits,
   input  logic [5:0]       req_code_length,
   input  logic             burst_free,
   output burst_type        burst
);

   logic              a_valid_ff, a_valid_in;
   logic [0:0]        a_func_ff;
   logic [31:0]       a_code_ff;
   logic [5:0]        a_len_ff;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CNT3_W-1:0] cnt_ff, cnt_in;

   logic              accept;
   logic              load;
   logic [LEN_W-1:0]  len;
   logic [ACC_W-1:0]  code_m;
   logic [ACC_W-1:0]  acc;
   logic [TOT_W-1:0]  total;
   logic [NB_W-1:0]   nbytes;

   assign req_stall = a_valid_ff && !burst_free;
   assign accept    = req_valid && !req_stall;
   assign load      = a_valid_ff && burst_free;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (load) begin
         a_valid_in = 1'b0;
      end
   end

   // saturate length, mask code to length, append behind pending bits; a flush emits the pending bits instead
   always_comb begin
      if (a_len_ff > LEN_W'(MAX_CODE_BITS)) begin
         len = LEN_W'(MAX_CODE_BITS);
      end else begin
         len = a_len_ff;
      end
      code_m = ACC_W'(a_code_ff) & ~({ACC_W{1'b1}} << len);
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      case (func_type'(a_func_ff))
         FUNC_FLUSH: begin
            acc    = ACC_W'(pend_ff);
            total  = TOT_W'(cnt_ff);
            nbytes = (cnt_ff != '0) ? NB_W'(1) : '0;
            if (load) begin
               pend_in = '0;
               cnt_in  = '0;
            end
         end
         default: begin
            acc    = (ACC_W'(pend_ff) << len) | code_m;
            total  = TOT_W'(cnt_ff) + TOT_W'(len);
            nbytes = NB_W'(total >> 3);
            if (load) begin
               cnt_in  = total[CNT3_W-1:0];
               pend_in = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[CNT3_W-1:0]);
            end
         end
      endcase
      burst.load   = load;
      burst.word   = acc << (TOT_W'(ACC_W) - total);
      burst.nbytes = nbytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         pend_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff <= req_func;
         a_code_ff <= req_code_bits;
         a_len_ff  <= req_code_length;
      end
   end

endmodule

// File: rtl/vlbp_emit.sv
// byte emitter: holds the packed word and sends one byte per cycle while rsp_stall does not hold the output
// depends on vlbp_pkg

module vlbp_emit
   import vlbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  burst_type  burst,
   output logic       burst_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic [ACC_W-1:0] word_ff, word_in;
   logic [NB_W-1:0]  remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic             out_free;
   logic             take;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign take       = (remain_ff != '0) && out_free;
   assign burst_free = (remain_ff == '0) || ((remain_ff == NB_W'(1)) && take);

   always_comb begin
      word_in   = word_ff;
      remain_in = remain_ff;
      if (burst.load) begin
         word_in   = burst.word;
         remain_in = burst.nbytes;
      end else if (take) begin
         word_in   = word_ff << 8;
         remain_in = remain_ff - NB_W'(1);
      end
      rsp_valid_in = out_free ? take : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (take) begin
         byte_ff <= word_ff[ACC_W-1 -: 8];
         last_ff <= (remain_ff == NB_W'(1));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// File: rtl/variable_length_bit_packer_core.sv
// variable-length bit packer, top level
// depends on vlbp_pkg, vlbp_pack and vlbp_emit
//
// usage
//   req channel: one transaction is a push (code right-aligned, length 0 to 32,
//   larger lengths saturate to 32) or a flush of the partial byte; accepted
//   when req_valid is high and req_stall is low
//   rsp channel: one transaction per packed byte, first bit in bit 7;
//   rsp_last marks the final byte caused by one request
//   path: the first byte of a request passes the input register, then the
//   packed-word register, then the output register before it shows on rsp
//   throughput: one request per cycle while each yields at most one byte
//   and rsp_stall is low; a request yielding n bytes holds the emitter until
//   its n bytes are sent, up to 4 for a 32-bit code behind pending bits; the
//   byte emitter, one byte per cycle into the output register when not stalled, sets that rate
//   stall: rsp_stall freezes the output register, the emitter backs up and
//   req_stall rises once the input register is full; nothing is dropped
//   reset: pending bits cleared, all stages empty, no clearing pass

module variable_length_bit_packer_core
   import vlbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_func,
   input  logic [31:0] req_code_bits,
   input  logic [5:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   // packed word and its byte count, pack stage to emitter
   burst_type burst;
   logic      burst_free;

   vlbp_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .burst_free      (burst_free),
      .burst           (burst)
   );

   // serializes the word into bytes behind a registered output
   vlbp_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .burst        (burst),
      .burst_free   (burst_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
